// ===== sv/tlsm_pkg.sv =====
// Shared types and constants for the triangle list to strip merger.
// Depends on nothing; every other file of the block imports it.
package tlsm_pkg;

   // Width of the index fields on the channels.
   localparam int IndexWidth = 16;
   // Default for the number of index bits that take part in compares.
   localparam int IndexBitsDefault = 16;
   // One triangle causes at most this many results.
   localparam int MaxResults = 6;
   localparam int CountBits = $clog2(MaxResults + 1);

   // Strip command codes on the result channel.
   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_EMIT  = 2'd1,
      CMD_END   = 2'd2
   } cmd_type;

   // One triangle as it arrives on the request channel.
   typedef struct packed {
      logic [IndexWidth-1:0] index_a;
      logic [IndexWidth-1:0] index_b;
      logic [IndexWidth-1:0] index_c;
      logic                  first_of_draw;
      logic                  last_of_draw;
   } tri_type;

   // One result on the response channel.
   typedef struct packed {
      cmd_type               command;
      logic [IndexWidth-1:0] vertex_index;
      logic                  last_of_run;
   } result_type;

   // All results caused by one triangle, entry zero goes out first.
   typedef struct packed {
      result_type [MaxResults-1:0] entries;
      logic [CountBits-1:0]        count;
   } batch_type;

endpackage

// ===== sv/tlsm_if.sv =====
// Valid/ready channel interfaces for the triangle list to strip merger.
// Depends on tlsm_pkg for the payload types.
interface tlsm_req_if
   import tlsm_pkg::*;
();
   logic    valid;
   logic    ready;
   tri_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tlsm_rsp_if
   import tlsm_pkg::*;
();
   logic       valid;
   logic       ready;
   result_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tlsm_strip_core.sv =====
// Strip decision logic: previous triangle, parity and strip state, and the
// result list that one accepted triangle causes. Depends on tlsm_pkg.
module tlsm_strip_core
   import tlsm_pkg::*;
#(
   parameter int INDEX_BITS = IndexBitsDefault
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  tri_type   tri_in,
   output batch_type batch
);

   // Only the low bits of each index take part; never more than the field holds.
   localparam int KeepBits = (INDEX_BITS < IndexWidth) ? INDEX_BITS : IndexWidth;

   logic [KeepBits-1:0] prev_first_ff, prev_first_in;
   logic [KeepBits-1:0] prev_second_ff, prev_second_in;
   logic [KeepBits-1:0] prev_third_ff, prev_third_in;
   logic                even_ff, even_in;
   logic                open_ff, open_in;

   logic [KeepBits-1:0] idx_a, idx_b, idx_c;
   logic                cont;
   logic [CountBits-1:0] k;

   assign idx_a = tri_in.index_a[KeepBits-1:0];
   assign idx_b = tri_in.index_b[KeepBits-1:0];
   assign idx_c = tri_in.index_c[KeepBits-1:0];

   // A triangle continues the strip when its leading edge matches the
   // trailing edge of the previous one, with the winding set by parity.
   always_comb begin
      cont = 1'b0;
      if (open_ff && !tri_in.first_of_draw) begin
         if (!even_ff) begin
            cont = (idx_a == prev_third_ff) && (idx_b == prev_second_ff);
         end else begin
            cont = (idx_a == prev_first_ff) && (idx_b == prev_third_ff);
         end
      end
   end

   // Build the result list and the next state for this triangle.
   always_comb begin
      batch = '0;
      k = '0;
      even_in = even_ff;
      open_in = open_ff;
      if (cont) begin
         batch.entries[k] = '{CMD_EMIT, IndexWidth'(idx_c), 1'b0};
         k = k + 1'b1;
         even_in = !even_ff;
      end else begin
         if (open_ff) begin
            batch.entries[k] = '{CMD_END, '0, 1'b0};
            k = k + 1'b1;
         end
         batch.entries[k] = '{CMD_BEGIN, '0, 1'b0};
         k = k + 1'b1;
         batch.entries[k] = '{CMD_EMIT, IndexWidth'(idx_a), 1'b0};
         k = k + 1'b1;
         batch.entries[k] = '{CMD_EMIT, IndexWidth'(idx_b), 1'b0};
         k = k + 1'b1;
         batch.entries[k] = '{CMD_EMIT, IndexWidth'(idx_c), 1'b0};
         k = k + 1'b1;
         even_in = 1'b0;
         open_in = 1'b1;
      end
      if (tri_in.last_of_draw) begin
         batch.entries[k] = '{CMD_END, '0, 1'b0};
         k = k + 1'b1;
         even_in = 1'b0;
         open_in = 1'b0;
      end
      // The final result of the list closes the run of this triangle.
      batch.entries[k - 1'b1].last_of_run = 1'b1;
      batch.count = k;
      prev_first_in = idx_a;
      prev_second_in = idx_b;
      prev_third_in = idx_c;
   end

   // State registers advance only on an accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_first_ff <= '0;
         prev_second_ff <= '0;
         prev_third_ff <= '0;
         even_ff <= 1'b0;
         open_ff <= 1'b0;
      end else if (accept) begin
         prev_first_ff <= prev_first_in;
         prev_second_ff <= prev_second_in;
         prev_third_ff <= prev_third_in;
         even_ff <= even_in;
         open_ff <= open_in;
      end
   end

   // A triangle that ends its draw leaves no strip open and odd parity.
   assert property (@(posedge clock) disable iff (reset)
      accept && tri_in.last_of_draw |=> !open_ff && !even_ff)
      else $error("strip left open after last triangle of draw");

   // Any other accepted triangle leaves a strip open.
   assert property (@(posedge clock) disable iff (reset)
      accept && !tri_in.last_of_draw |=> open_ff)
      else $error("no open strip after triangle");

   // A continuing triangle flips the parity.
   assert property (@(posedge clock) disable iff (reset)
      accept && cont && !tri_in.last_of_draw |=> even_ff != $past(even_ff))
      else $error("parity did not flip on continuation");

endmodule

// ===== sv/tlsm_result_queue.sv =====
// Result buffer: holds the list of one triangle and sends it out one
// result per cycle while the receiver is ready, shifting toward the head. Depends on tlsm_pkg, tlsm_if.
module tlsm_result_queue
   import tlsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  batch_type         batch_in,
   output logic              load_ok,
   tlsm_rsp_if.source        rsp
);

   result_type [MaxResults-1:0] entries_ff, entries_in;
   logic [CountBits-1:0]        count_ff, count_in;
   logic                        pop;

   assign rsp.valid = (count_ff != '0);
   assign rsp.data = entries_ff[0];
   assign pop = rsp.valid && rsp.ready;
   // A new list may enter when the buffer is empty or drains in this cycle.
   assign load_ok = (count_ff == '0) || ((count_ff == CountBits'(1)) && pop);

   // Next contents: a fresh list, or the current one moved up one place.
   always_comb begin
      entries_in = entries_ff;
      count_in = count_ff;
      if (load) begin
         entries_in = batch_in.entries;
         count_in = batch_in.count;
      end else if (pop) begin
         for (int i = 0; i < MaxResults - 1; i++) begin
            entries_in[i] = entries_ff[i + 1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   // The fill count never runs past the list length.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(MaxResults))
      else $error("result buffer overfilled");

   // The run marker sits exactly on the last result held.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.data.last_of_run == (count_ff == CountBits'(1))))
      else $error("run marker misplaced");

   // A loaded list takes the place of whatever was there.
   assert property (@(posedge clock) disable iff (reset)
      load |=> (count_ff == $past(batch_in.count)) && (count_ff != '0))
      else $error("list not loaded");

endmodule

// ===== sv/triangle_list_strip_merger.sv =====
// Triangle list to strip merger. The first result of an accepted triangle
// is offered in the cycle after acceptance. One triangle per cycle while each
// causes one result and the output is ready; otherwise one result per cycle
// while ready, and a new triangle waits until the last result goes out.
// Synchronous active-high reset clears strip state and empties the buffer.
module triangle_list_strip_merger
   import tlsm_pkg::*;
#(
   parameter int INDEX_BITS = IndexBitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   tlsm_req_if.sink   req,
   tlsm_rsp_if.source rsp
);

   batch_type batch;
   logic      load_ok;
   logic      accept;

   assign req.ready = load_ok;
   assign accept = req.valid && load_ok;

   // Strip decision and state.
   tlsm_strip_core #(
      .INDEX_BITS(INDEX_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .tri_in(req.data),
      .batch (batch)
   );

   // Result buffer toward the output channel.
   tlsm_result_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .batch_in(batch),
      .load_ok (load_ok),
      .rsp     (rsp)
   );

endmodule
